// ===== rtl/core/frame_pool_and_queue_manager_defines.svh =====
// assertion macros shared by the rtl files
// the including module must have clk and rst_n in scope
`ifndef FRAME_POOL_AND_QUEUE_MANAGER_DEFINES_SVH
`define FRAME_POOL_AND_QUEUE_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FPQM_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: invariant violated");

`define FPQM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`define FPQM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define FPQM_ASSERT_ALW(lbl, cond)
`define FPQM_ASSERT_IMP(lbl, ante, cons)
`define FPQM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/fpqm_pkg.sv =====
`timescale 1ns / 1ps

package fpqm_pkg;

  localparam int TYPE_W     = 3;
  localparam int IDX_W      = 3;
  localparam int STAT_W     = 3;
  localparam int FIU_W      = 4;
  localparam int CNT_W      = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  typedef enum logic [TYPE_W-1:0] {
    REQ_BORROW = 3'd0,
    REQ_GIVE   = 3'd1,
    REQ_PUSH   = 3'd2,
    REQ_POP    = 3'd3,
    REQ_STOP   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_STOPPED   = 3'd4
  } status_t;

  // command from the request decoder to the pool
  typedef struct packed {
    logic             borrow;
    logic             give;
    logic [IDX_W-1:0] give_idx;
  } pool_cmd_t;

  // pool status back to the request decoder
  typedef struct packed {
    logic             ready;
    logic             done;
    logic             found;
    logic [IDX_W-1:0] res_idx;
  } pool_sts_t;

endpackage

// ===== rtl/core/fpqm_req_if.sv =====
`timescale 1ns / 1ps

interface fpqm_req_if;
  import fpqm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [IDX_W-1:0]  frame_index;

  modport source (output valid, output req_type, output frame_index, input ready);
  modport sink   (input valid, input req_type, input frame_index, output ready);
endinterface

// ===== rtl/core/fpqm_rsp_if.sv =====
`timescale 1ns / 1ps

interface fpqm_rsp_if;
  import fpqm_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result_index, output status, input ready);
  modport sink   (input valid, input result_index, input status, output ready);
endinterface

// ===== rtl/core/fpqm_pool.sv =====
`timescale 1ns / 1ps
`include "frame_pool_and_queue_manager_defines.svh"

module fpqm_pool #(
  parameter int POOL_SIZE = 8,
  localparam int PTR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
  localparam int CMP_W = (PTR_W + 1 > fpqm_pkg::CNT_W) ? PTR_W + 1 : fpqm_pkg::CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpqm_pkg::pool_cmd_t cmd,
  input  logic [CMP_W-1:0]    n_len,
  output fpqm_pkg::pool_sts_t sts
);
  import fpqm_pkg::*;

  localparam logic [CMP_W-1:0] POOL_LIM = CMP_W'(POOL_SIZE);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(POOL_SIZE - 1);

  typedef enum logic [1:0] {P_CLEAR, P_IDLE, P_SCAN} pool_state_t;

  function automatic logic [PTR_W-1:0] fit_ptr(input logic [PTR_W-1:0] p,
                                               input logic [CMP_W-1:0] n);
    fit_ptr = (CMP_W'(p) >= n) ? '0 : p;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CMP_W-1:0] n);
    logic [CMP_W-1:0] p1;
    p1 = CMP_W'(p) + 1'b1;
    next_ptr = (p1 >= n) ? '0 : p1[PTR_W-1:0];
  endfunction

  pool_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] clr_r, clr_nxt;
  logic [PTR_W-1:0] slot_r, slot_nxt;
  logic [CMP_W-1:0] left_r, left_nxt;
  logic [CMP_W-1:0] n_r, n_nxt;

  // busy flags, one bit per frame
  logic             busy_mem [POOL_SIZE];
  logic             flag_q;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic [PTR_W-1:0] mem_raddr;

  logic [PTR_W-1:0] head_fit;
  logic [PTR_W-1:0] slot_next;
  logic [CMP_W-1:0] give_ext;

  assign head_fit  = fit_ptr(head_r, n_len);
  assign slot_next = next_ptr(slot_r, n_r);
  assign give_ext  = CMP_W'(cmd.give_idx);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    clr_nxt     = clr_r;
    slot_nxt    = slot_r;
    left_nxt    = left_r;
    n_nxt       = n_r;
    mem_we      = 1'b0;
    mem_waddr   = clr_r;
    mem_wdata   = 1'b0;
    mem_raddr   = head_fit;
    sts.ready   = (state_r == P_IDLE);
    sts.done    = 1'b0;
    sts.found   = 1'b0;
    sts.res_idx = IDX_W'(slot_r);
    case (state_r)
      P_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = P_IDLE;
        end
      end
      P_IDLE: begin
        if (cmd.give && (give_ext < POOL_LIM)) begin
          mem_we    = 1'b1;
          mem_waddr = give_ext[PTR_W-1:0];
        end
        if (cmd.borrow) begin
          slot_nxt  = head_fit;
          left_nxt  = n_len - 1'b1;
          n_nxt     = n_len;
          state_nxt = P_SCAN;
        end
      end
      P_SCAN: begin
        // flag_q belongs to slot_r; the next slot is read ahead
        if (!flag_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = 1'b1;
          sts.done  = 1'b1;
          sts.found = 1'b1;
          head_nxt  = slot_next;
          state_nxt = P_IDLE;
        end else if (left_r == '0) begin
          sts.done  = 1'b1;
          head_nxt  = slot_next;
          state_nxt = P_IDLE;
        end else begin
          mem_raddr = slot_next;
          slot_nxt  = slot_next;
          left_nxt  = left_r - 1'b1;
        end
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_CLEAR;
      head_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      clr_r   <= clr_nxt;
    end
    slot_r <= slot_nxt;
    left_r <= left_nxt;
    n_r    <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[mem_waddr] <= mem_wdata;
    end
    flag_q <= busy_mem[mem_raddr];
  end

  `FPQM_ASSERT_IMP(a_scan_left, state_r == P_SCAN, left_r < n_r)
  `FPQM_ASSERT_IMP(a_borrow_idle, cmd.borrow, state_r == P_IDLE)
  `FPQM_ASSERT_IMP(a_clear_quiet, state_r == P_CLEAR, !cmd.borrow && !cmd.give)

endmodule

// ===== rtl/core/frame_pool_and_queue_manager.sv =====
`timescale 1ns / 1ps
// results: give back, push, stop, a refused pop and unknown types are decided when accepted;
//   a pop first registers the queue entry; a borrow scans up to n flags, n the pool length
// throughput: one item at a time, the next accepted once the result is registered;
//   a borrow is set by the busy-flag memory, one flag read per cycle
// reset: synchronous, active low; a clearing pass then frees every
//   busy flag while no item is accepted (configuration writes are still taken)
`include "frame_pool_and_queue_manager_defines.svh"

module frame_pool_and_queue_manager #(
  parameter int POOL_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fpqm_req_if.sink                        in_ch,
  fpqm_rsp_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpqm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fpqm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fpqm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fpqm_pkg::*;

  localparam int PTR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
  localparam logic [CMP_W-1:0] POOL_LIM = CMP_W'(POOL_SIZE);

  // register index is the word address bit above the byte offset
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {T_IDLE, T_BORROW, T_POP, T_HOLD} top_state_t;

  function automatic logic [PTR_W-1:0] fit_ptr(input logic [PTR_W-1:0] p,
                                               input logic [CMP_W-1:0] n);
    fit_ptr = (CMP_W'(p) >= n) ? '0 : p;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CMP_W-1:0] n);
    logic [CMP_W-1:0] p1;
    p1 = CMP_W'(p) + 1'b1;
    next_ptr = (p1 >= n) ? '0 : p1[PTR_W-1:0];
  endfunction

  // control state
  top_state_t        state_r, state_nxt;
  logic [FIU_W-1:0]  fiu_r, fiu_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              stop_r, stop_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [IDX_W-1:0]  hold_idx_r, hold_idx_nxt;
  status_t           hold_st_r, hold_st_nxt;

  // queue of frame indices
  logic [IDX_W-1:0]  q_mem [POOL_SIZE];
  logic [IDX_W-1:0]  q_rd_r;
  logic              q_we;

  logic              in_acc;
  logic              cfg_wr;
  logic [CMP_W-1:0]  n_len;
  logic [PTR_W-1:0]  wr_fit;
  logic [PTR_W-1:0]  rd_fit;
  logic              res_vld;
  logic [IDX_W-1:0]  res_idx;
  status_t           res_st;
  pool_cmd_t         pcmd;
  pool_sts_t         psts;

  fpqm_pool #(
    .POOL_SIZE (POOL_SIZE)
  ) u_pool (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pcmd),
    .n_len (n_len),
    .sts   (psts)
  );

  // effective pool length: zero acts as one, capped at the pool size
  always_comb begin
    if (fiu_r == '0) begin
      n_len = CMP_W'(1);
    end else if (CMP_W'(fiu_r) > POOL_LIM) begin
      n_len = POOL_LIM;
    end else begin
      n_len = CMP_W'(fiu_r);
    end
  end

  // pointers left beyond a shrunk pool act as zero
  assign wr_fit = fit_ptr(wr_ptr_r, n_len);
  assign rd_fit = fit_ptr(rd_ptr_r, n_len);

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == T_IDLE) && psts.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.status       = out_st_r;

  // configuration port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE) ? CFG_DATA_W'(fiu_r) : '0;
  assign fiu_nxt = cfg_wr ? pwdata[FIU_W-1:0] : fiu_r;

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    hold_idx_nxt  = hold_idx_r;
    hold_st_nxt   = hold_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    res_vld       = 1'b0;
    res_idx       = '0;
    res_st        = ST_OK;
    q_we          = 1'b0;
    pcmd.borrow   = 1'b0;
    pcmd.give     = 1'b0;
    pcmd.give_idx = in_ch.frame_index;

    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          case (in_ch.req_type)
            REQ_BORROW: begin
              pcmd.borrow = 1'b1;
              state_nxt   = T_BORROW;
            end
            REQ_GIVE: begin
              pcmd.give = 1'b1;
              res_vld   = 1'b1;
            end
            REQ_PUSH: begin
              res_vld = 1'b1;
              if (CMP_W'(cnt_r) >= n_len) begin
                res_st = ST_FULL;
              end else begin
                q_we       = 1'b1;
                wr_ptr_nxt = next_ptr(wr_fit, n_len);
                cnt_nxt    = cnt_r + 1'b1;
              end
            end
            REQ_POP: begin
              if (stop_r) begin
                res_vld = 1'b1;
                res_st  = ST_STOPPED;
              end else if (cnt_r == '0) begin
                res_vld = 1'b1;
                res_st  = ST_EMPTY;
              end else begin
                // entry is read at this edge, result in the next cycle
                rd_ptr_nxt = next_ptr(rd_fit, n_len);
                cnt_nxt    = cnt_r - 1'b1;
                state_nxt  = T_POP;
              end
            end
            REQ_STOP: begin
              stop_nxt = 1'b1;
              res_vld  = 1'b1;
            end
            default: res_vld = 1'b1;
          endcase
        end
      end
      T_BORROW: begin
        if (psts.done) begin
          res_vld = 1'b1;
          res_idx = psts.found ? psts.res_idx : '0;
          res_st  = psts.found ? ST_OK : ST_EXHAUSTED;
        end
      end
      T_POP: begin
        res_vld = 1'b1;
        res_idx = q_rd_r;
      end
      T_HOLD: begin
        res_vld = 1'b1;
        res_idx = hold_idx_r;
        res_st  = hold_st_r;
      end
      default: state_nxt = T_IDLE;
    endcase

    // finished result goes to the output register, or waits while it is full
    if (res_vld) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = res_idx;
        out_st_nxt    = res_st;
        state_nxt     = T_IDLE;
      end else begin
        hold_idx_nxt = res_idx;
        hold_st_nxt  = res_st;
        state_nxt    = T_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      fiu_r       <= FIU_RESET;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fiu_r       <= fiu_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
    hold_idx_r <= hold_idx_nxt;
    hold_st_r  <= hold_st_nxt;
  end

  // queue store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wr_fit] <= in_ch.frame_index;
    end
    q_rd_r <= q_mem[rd_fit];
  end

  `FPQM_ASSERT_ALW(a_cnt_bound, CMP_W'(cnt_r) <= POOL_LIM)
  `FPQM_ASSERT_NXT(a_push_count, q_we, cnt_r == $past(cnt_r) + 1'b1)
  `FPQM_ASSERT_IMP(a_hold_full, state_r == T_HOLD, out_valid_r)
  `FPQM_ASSERT_NXT(a_stop_sticky, stop_r, stop_r)

endmodule
